[design/dpoq_pkg.sv]
// Package for the deadline priority output queue.
// Holds payload structs, request codes and the cell chain word types.
// No dependencies.
package dpoq_pkg;

    localparam int DEADLINE_BITS = 32;
    localparam int TAG_BITS      = 8;
    localparam int COUNT_BITS    = 5;

    // request kinds carried in req_type
    localparam logic [1:0] REQ_FLIT = 2'd0;
    localparam logic [1:0] REQ_RESP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [TAG_BITS-1:0]      flit_id;
        logic [DEADLINE_BITS-1:0] deadline;
        logic                     grant;
    } in_word_t;

    typedef struct packed {
        logic                     req_valid;
        logic [DEADLINE_BITS-1:0] req_deadline;
        logic [TAG_BITS-1:0]      req_flit_id;
        logic                     inject_valid;
        logic [TAG_BITS-1:0]      inject_flit_id;
        logic                     recycled;
        logic [COUNT_BITS-1:0]    queue_count;
        logic                     overflow;
        logic                     protocol_error;
    } out_word_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                     wr_en;
        logic                     clr_en;
        logic [TAG_BITS-1:0]      tag;
        logic [DEADLINE_BITS-1:0] deadline;
    } cell_cmd_t;

    // best-so-far candidate handed from cell to cell
    typedef struct packed {
        logic                     found;
        logic [TAG_BITS-1:0]      tag;
        logic [DEADLINE_BITS-1:0] deadline;
    } scan_t;

endpackage

[design/deadline_priority_output_queue.sv]
// Top level of the deadline priority output queue: controller, stage and cell chain.
// Depends on dpoq_pkg and dpoq_cell.
//
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | s_data (dpoq_pkg::in_word_t)
//  m_      | out | m_valid / m_ready  | m_data (dpoq_pkg::out_word_t)
//
// Arrivals, responses, unused codes and ticks while waiting are handled in ST_IDLE.
// A tick that reloads the stage runs ST_SEARCH, then ST_TAKE: the min scan walks the
// cell chain one cell per cycle; ST_TAKE takes the last cell's word when out_free.
// aresetn is synchronous, active low; it empties every slot and the stage.
// s_ready is low while a tick is in progress and while the result register is
// full and not being taken; a stalled result holds.
module deadline_priority_output_queue #(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dpoq_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpoq_pkg::out_word_t  m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CB    = dpoq_pkg::COUNT_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_TAKE} state_t;
    typedef enum logic [1:0] {PH_EMPTY, PH_WAIT, PH_READY} phase_t;

    state_t                             state_reg, state_next;
    phase_t                             phase_reg, phase_next;
    logic [IDX_W-1:0]                   scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [dpoq_pkg::DEADLINE_BITS-1:0] stage_dl_reg, stage_dl_next;
    logic [dpoq_pkg::TAG_BITS-1:0]      stage_tag_reg, stage_tag_next;
    logic                               stage_grant_reg, stage_grant_next;
    logic                               pend_inject_reg, pend_inject_next;
    logic [dpoq_pkg::TAG_BITS-1:0]      pend_tag_reg, pend_tag_next;
    logic                               pend_recycled_reg, pend_recycled_next;
    logic                               pend_overflow_reg, pend_overflow_next;
    logic                               m_valid_reg, m_valid_next;
    dpoq_pkg::out_word_t                m_data_reg, m_data_next;

    dpoq_pkg::cell_cmd_t cmd;
    dpoq_pkg::scan_t     scan_bus [DEPTH+1];
    logic [IDX_W-1:0]    idx_bus  [DEPTH+1];
    logic [DEPTH:0]      claim_bus;
    logic [DEPTH-1:0]    valid_vec;
    logic [CNT_W+CB-1:0] cnt_wide;
    logic                full;
    logic                out_free;
    logic                accept;
    logic                load_out;

    assign scan_bus[0] = '0;
    assign idx_bus[0]  = '0;
    assign claim_bus[0] = 1'b1;
    assign full = claim_bus[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        dpoq_cell #(
            .IDX_W(IDX_W),
            .SLOT (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .clr_idx     (idx_bus[DEPTH]),
            .claim_in    (claim_bus[i]),
            .claim_out   (claim_bus[i+1]),
            .scan_in     (scan_bus[i]),
            .scan_idx_in (idx_bus[i]),
            .scan_out    (scan_bus[i+1]),
            .scan_idx_out(idx_bus[i+1]),
            .valid       (valid_vec[i])
        );
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        scan_cnt_next      = scan_cnt_reg;
        count_next         = count_reg;
        stage_dl_next      = stage_dl_reg;
        stage_tag_next     = stage_tag_reg;
        stage_grant_next   = stage_grant_reg;
        pend_inject_next   = pend_inject_reg;
        pend_tag_next      = pend_tag_reg;
        pend_recycled_next = pend_recycled_reg;
        pend_overflow_next = pend_overflow_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;
        cmd                = '0;
        load_out           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next = '0;
                    unique case (s_data.req_type)
                        dpoq_pkg::REQ_FLIT: begin
                            load_out = 1'b1;
                            if (full) begin
                                m_data_next.overflow = 1'b1;
                            end else begin
                                cmd.wr_en    = 1'b1;
                                cmd.tag      = s_data.flit_id;
                                cmd.deadline = s_data.deadline;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        dpoq_pkg::REQ_RESP: begin
                            load_out = 1'b1;
                            if (phase_reg == PH_WAIT) begin
                                phase_next       = PH_READY;
                                stage_grant_next = s_data.grant;
                            end else begin
                                m_data_next.protocol_error = 1'b1;
                            end
                        end
                        dpoq_pkg::REQ_TICK: begin
                            if (phase_reg == PH_WAIT) begin
                                load_out = 1'b1;
                            end else begin
                                pend_inject_next   = 1'b0;
                                pend_tag_next      = '0;
                                pend_recycled_next = 1'b0;
                                pend_overflow_next = 1'b0;
                                if (phase_reg == PH_READY) begin
                                    if (stage_grant_reg) begin
                                        pend_inject_next = 1'b1;
                                        pend_tag_next    = stage_tag_reg;
                                    end else if (full) begin
                                        pend_overflow_next = 1'b1;
                                    end else begin
                                        // denied flit goes back into the store
                                        cmd.wr_en          = 1'b1;
                                        cmd.tag            = stage_tag_reg;
                                        cmd.deadline       = stage_dl_reg;
                                        count_next         = count_reg + 1'b1;
                                        pend_recycled_next = 1'b1;
                                    end
                                end
                                phase_next       = PH_EMPTY;
                                stage_dl_next    = '0;
                                stage_tag_next   = '0;
                                stage_grant_next = 1'b0;
                                scan_cnt_next    = '0;
                                state_next       = ST_SEARCH;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(DEPTH - 1)) begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE: begin
                if (out_free) begin
                    load_out                   = 1'b1;
                    m_data_next                = '0;
                    m_data_next.inject_valid   = pend_inject_reg;
                    m_data_next.inject_flit_id = pend_tag_reg;
                    m_data_next.recycled       = pend_recycled_reg;
                    m_data_next.overflow       = pend_overflow_reg;
                    if (scan_bus[DEPTH].found) begin
                        // loaded flit requests at once and waits for the response
                        cmd.clr_en               = 1'b1;
                        count_next               = count_reg - 1'b1;
                        stage_dl_next            = scan_bus[DEPTH].deadline;
                        stage_tag_next           = scan_bus[DEPTH].tag;
                        phase_next               = PH_WAIT;
                        m_data_next.req_valid    = 1'b1;
                        m_data_next.req_deadline = scan_bus[DEPTH].deadline;
                        m_data_next.req_flit_id  = scan_bus[DEPTH].tag;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        cnt_wide = {{CB{1'b0}}, count_next};
        if (load_out) begin
            m_valid_next            = 1'b1;
            m_data_next.queue_count = cnt_wide[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_EMPTY;
            scan_cnt_reg    <= '0;
            count_reg       <= '0;
            stage_dl_reg    <= '0;
            stage_tag_reg   <= '0;
            stage_grant_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            scan_cnt_reg    <= scan_cnt_next;
            count_reg       <= count_next;
            stage_dl_reg    <= stage_dl_next;
            stage_tag_reg   <= stage_tag_next;
            stage_grant_reg <= stage_grant_next;
            m_valid_reg     <= m_valid_next;
        end
        pend_inject_reg   <= pend_inject_next;
        pend_tag_reg      <= pend_tag_next;
        pend_recycled_reg <= pend_recycled_next;
        pend_overflow_reg <= pend_overflow_next;
        m_data_reg        <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // occupancy counter tracks the slot valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("held count differs from occupied slots");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("held count above depth");

    a_req_sets_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAKE && out_free && scan_bus[DEPTH].found) |=> (phase_reg == PH_WAIT))
        else $error("request issued without entering wait phase");

    a_inject_xor_recycle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.inject_valid && m_data_reg.recycled))
        else $error("flit both injected and recycled");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> !s_ready)
        else $error("input accepted during scan");

endmodule

[design/dpoq_cell.sv]
// One slot of the deadline queue: entry storage plus one stage of the min-scan chain.
// Depends on dpoq_pkg.
module dpoq_cell #(
    parameter int IDX_W = 4,
    parameter int SLOT  = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dpoq_pkg::cell_cmd_t cmd,
    input  logic [IDX_W-1:0]  clr_idx,
    input  logic              claim_in,
    output logic              claim_out,
    input  dpoq_pkg::scan_t   scan_in,
    input  logic [IDX_W-1:0]  scan_idx_in,
    output dpoq_pkg::scan_t   scan_out,
    output logic [IDX_W-1:0]  scan_idx_out,
    output logic              valid
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

    logic                              valid_reg;
    logic [dpoq_pkg::TAG_BITS-1:0]      tag_reg;
    logic [dpoq_pkg::DEADLINE_BITS-1:0] dl_reg;
    dpoq_pkg::scan_t                   scan_reg;
    logic [IDX_W-1:0]                  scan_idx_reg;

    logic write_here;
    logic clear_here;
    logic take_own;

    // insert goes to the first free slot: claim ripples past occupied cells
    assign write_here = cmd.wr_en && claim_in && !valid_reg;
    assign claim_out  = claim_in && valid_reg;
    assign clear_here = cmd.clr_en && (clr_idx == MY_IDX);
    // strict compare keeps the lower slot on equal deadlines
    assign take_own   = valid_reg && (!scan_in.found || (dl_reg < scan_in.deadline));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            scan_reg.found <= 1'b0;
        end else begin
            if (write_here) begin
                valid_reg <= 1'b1;
            end else if (clear_here) begin
                valid_reg <= 1'b0;
            end
            scan_reg.found <= scan_in.found || valid_reg;
        end
        if (write_here) begin
            tag_reg <= cmd.tag;
            dl_reg  <= cmd.deadline;
        end
        if (take_own) begin
            scan_reg.tag      <= tag_reg;
            scan_reg.deadline <= dl_reg;
            scan_idx_reg      <= MY_IDX;
        end else begin
            scan_reg.tag      <= scan_in.tag;
            scan_reg.deadline <= scan_in.deadline;
            scan_idx_reg      <= scan_idx_in;
        end
    end

    assign scan_out     = scan_reg;
    assign scan_idx_out = scan_idx_reg;
    assign valid        = valid_reg;

endmodule
